// ===== design/pfsa_pkg.sv =====
// Package for the page frame free-stack allocator.
// Holds payload structs, codes and the controller/datapath command types.
// No dependencies.
package pfsa_pkg;

	localparam int ADDR_W    = 64;
	localparam int RTYPE_W   = 32;
	localparam int KIND_W    = 2;
	localparam int STATUS_W  = 3;
	localparam int PAGES_W   = 13;
	localparam int CFG_IDX_W = 2;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_MISALIGNED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] REG_VIRT_OFFSET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_END  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MEMORY_END  = 2'd2;

	localparam logic [RTYPE_W-1:0] RTYPE_USABLE_RAM = 32'd1;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [ADDR_W-1:0]  address;
		logic [ADDR_W-1:0]  length;
		logic [RTYPE_W-1:0] region_type;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   page_vaddr;
		logic [PAGES_W-1:0]  pages_added;
	} out_item_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,    // capture item, virtual start
		OP_RANGE,   // virtual end, low clip
		OP_CLIP,    // high clip, first page
		OP_LIMIT,   // last page start, empty test
		OP_WALK,    // push one region page
		OP_FREE,    // check and push one page
		OP_POP,     // read top of stack
		OP_POPW     // form popped address
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   post;   // move result into output register
	} dp_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] in_kind;
		logic              in_usable;
		logic              walk_done;
		logic              out_free;
	} dp_sts_t;

endpackage

// ===== design/page_frame_free_stack_allocator.sv =====
// Top level of the page frame free-stack allocator.
// Depends on pfsa_pkg, pfsa_ctrl and pfsa_dp.
//
// Usage:
//  - in channel (in_valid/in_stall/in_data): one item per beat: add region,
//    free page or allocate page. out channel: exactly one result beat per item.
//  - cfg port: cfg_we/cfg_index/cfg_data write virtual offset, kernel end and
//    memory end; write only while no item is in flight. Index 3 is ignored.
//  - Items are worked one at a time by the controller; the sequencer steps
//    after an item is accepted are: free page: check and push; allocate:
//    registered stack read, then form the address; other kind or unusable
//    region: none; usable region: range, clip, limit, then the walk, which
//    pushes one page per cycle through the single stack write port.
//  - The result sits in an output register; out_valid is registered with it
//    when the done step posts the result. While out_stall holds it, the next
//    item is still accepted and worked; it then waits in its final step until
//    the output register frees, and in_stall stays high meanwhile.
//  - Reset (arst_n low) empties the stack, clears config to zero and drops
//    out_valid. Stack memory is not cleared: only entries below the fill
//    count are ever read. No clearing pass, so items are taken right away.
//  - Region items saturate their address sums and stop at a full stack with
//    status full; pages_added gives what was pushed.
module page_frame_free_stack_allocator #(
	parameter int PAGE_SHIFT  = 12,
	parameter int STACK_DEPTH = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pfsa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pfsa_pkg::ADDR_W-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  pfsa_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output pfsa_pkg::out_item_t            out_data
);

	pfsa_pkg::dp_cmd_t cmd;
	pfsa_pkg::dp_sts_t sts;

	pfsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	pfsa_dp #(
		.PAGE_SHIFT  (PAGE_SHIFT),
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ===== design/pfsa_ctrl.sv =====
// Controller for the page frame allocator: sequences one item at a time.
// Depends on pfsa_pkg; drives pfsa_dp through dp_cmd_t, reads dp_sts_t.
module pfsa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  pfsa_pkg::dp_sts_t sts,
	output pfsa_pkg::dp_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_RANGE,
		S_CLIP,
		S_LIMIT,
		S_WALK,
		S_FREE,
		S_POP,
		S_POPW,
		S_DONE
	} state_t;

	state_t state_q;
	logic   can_take;
	logic   accept;

	assign can_take = (state_q == S_IDLE) || (state_q == S_DONE && sts.out_free);
	assign in_stall = !can_take;
	assign accept   = in_valid && can_take;

	always_comb begin
		cmd.post = (state_q == S_DONE) && sts.out_free;
		cmd.op   = pfsa_pkg::OP_NONE;
		case (state_q)
			S_IDLE, S_DONE: cmd.op = accept ? pfsa_pkg::OP_LOAD : pfsa_pkg::OP_NONE;
			S_RANGE:        cmd.op = pfsa_pkg::OP_RANGE;
			S_CLIP:         cmd.op = pfsa_pkg::OP_CLIP;
			S_LIMIT:        cmd.op = pfsa_pkg::OP_LIMIT;
			S_WALK:         cmd.op = pfsa_pkg::OP_WALK;
			S_FREE:         cmd.op = pfsa_pkg::OP_FREE;
			S_POP:          cmd.op = pfsa_pkg::OP_POP;
			S_POPW:         cmd.op = pfsa_pkg::OP_POPW;
			default:        cmd.op = pfsa_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE, S_DONE: begin
					if (accept) begin
						case (sts.in_kind)
							pfsa_pkg::KIND_ADD:   state_q <= sts.in_usable ? S_RANGE : S_DONE;
							pfsa_pkg::KIND_FREE:  state_q <= S_FREE;
							pfsa_pkg::KIND_ALLOC: state_q <= S_POP;
							default:              state_q <= S_DONE;
						endcase
					end else if (state_q == S_DONE && sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_RANGE: state_q <= S_CLIP;
				S_CLIP:  state_q <= S_LIMIT;
				S_LIMIT: state_q <= S_WALK;
				S_WALK: begin
					if (sts.walk_done)
						state_q <= S_DONE;
				end
				S_FREE:  state_q <= S_DONE;
				S_POP:   state_q <= S_POPW;
				S_POPW:  state_q <= S_DONE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== design/pfsa_dp.sv =====
// Datapath for the page frame allocator: config registers, address arithmetic,
// free stack memory, fill count and output register. Depends on pfsa_pkg.
module pfsa_dp #(
	parameter int PAGE_SHIFT  = 12,
	parameter int STACK_DEPTH = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pfsa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pfsa_pkg::ADDR_W-1:0]         cfg_data,
	input  pfsa_pkg::in_item_t                  in_data,
	input  logic                                out_stall,
	output logic                                out_valid,
	output pfsa_pkg::out_item_t                 out_data,
	input  pfsa_pkg::dp_cmd_t                   cmd,
	output pfsa_pkg::dp_sts_t                   sts
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int FW = pfsa_pkg::ADDR_W - PAGE_SHIFT;
	localparam logic [pfsa_pkg::ADDR_W-1:0] PAGE_BYTES = 64'd1 << PAGE_SHIFT;
	localparam logic [pfsa_pkg::ADDR_W-1:0] PAGE_MASK  = PAGE_BYTES - 64'd1;
	localparam logic [pfsa_pkg::ADDR_W-1:0] ADDR_MAX   = '1;
	localparam logic [CW-1:0]               DEPTH_C    = CW'(STACK_DEPTH);

	// config
	logic [pfsa_pkg::ADDR_W-1:0] voff_q, kend_q, mend_q;
	// item and region working registers
	logic [pfsa_pkg::ADDR_W-1:0] addr_q, len_q, vs_q, ve_q, lo_q, hi_q, cur_q, lim_q;
	logic                        lovf_q, bad_q;
	// stack
	logic [FW-1:0]               stack_mem [STACK_DEPTH];
	logic [FW-1:0]               rd_q;
	logic [CW-1:0]               count_q, added_q;
	// result
	logic [pfsa_pkg::STATUS_W-1:0] res_status_q;
	logic [pfsa_pkg::ADDR_W-1:0]   res_page_q;
	logic                          out_valid_q;
	pfsa_pkg::out_item_t           out_q;

	logic [pfsa_pkg::ADDR_W:0]   vs_sum, ve_sum;
	logic [pfsa_pkg::ADDR_W-1:0] vs_sat, ve_sat;
	logic                        stack_full, page_fits;
	logic                        free_mis, free_rng;
	logic                        push_en;
	logic [FW-1:0]               push_frame;
	logic [CW-1:0]               count_m1;

	assign vs_sum = {1'b0, in_data.address} + {1'b0, voff_q};
	assign vs_sat = vs_sum[pfsa_pkg::ADDR_W] ? ADDR_MAX : vs_sum[pfsa_pkg::ADDR_W-1:0];
	assign ve_sum = {1'b0, vs_q} + {1'b0, len_q};
	assign ve_sat = ve_sum[pfsa_pkg::ADDR_W] ? ADDR_MAX : ve_sum[pfsa_pkg::ADDR_W-1:0];

	assign stack_full = (count_q == DEPTH_C);
	assign page_fits  = !bad_q && (cur_q <= lim_q);
	assign count_m1   = count_q - CW'(1);

	assign free_mis = (addr_q[PAGE_SHIFT-1:0] != '0);
	assign free_rng = (addr_q < kend_q) || (mend_q < PAGE_BYTES) ||
	                  (addr_q > mend_q - PAGE_BYTES);

	always_comb begin
		push_en    = 1'b0;
		push_frame = cur_q[pfsa_pkg::ADDR_W-1:PAGE_SHIFT];
		case (cmd.op)
			pfsa_pkg::OP_WALK: push_en = page_fits && !stack_full;
			pfsa_pkg::OP_FREE: begin
				push_en    = !free_mis && !free_rng && !stack_full;
				push_frame = addr_q[pfsa_pkg::ADDR_W-1:PAGE_SHIFT];
			end
			default: push_en = 1'b0;
		endcase
	end

	assign sts.in_kind   = in_data.kind;
	assign sts.in_usable = (in_data.region_type == pfsa_pkg::RTYPE_USABLE_RAM);
	assign sts.walk_done = !page_fits || stack_full;
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voff_q <= '0;
			kend_q <= '0;
			mend_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pfsa_pkg::REG_VIRT_OFFSET: voff_q <= cfg_data;
				pfsa_pkg::REG_KERNEL_END:  kend_q <= cfg_data;
				pfsa_pkg::REG_MEMORY_END:  mend_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// fill count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (push_en)
				count_q <= count_q + CW'(1);
			else if (cmd.op == pfsa_pkg::OP_POP && count_q != '0)
				count_q <= count_m1;

			if (cmd.post)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// stack memory
	always_ff @(posedge clk) begin
		if (push_en)
			stack_mem[count_q[AW-1:0]] <= push_frame;
		if (cmd.op == pfsa_pkg::OP_POP && count_q != '0)
			rd_q <= stack_mem[count_m1[AW-1:0]];
	end

	// working registers and result
	always_ff @(posedge clk) begin
		if (cmd.post) begin
			out_q.status      <= res_status_q;
			out_q.page_vaddr  <= res_page_q;
			out_q.pages_added <= pfsa_pkg::PAGES_W'(added_q);
		end
		if (push_en)
			added_q <= added_q + CW'(1);
		case (cmd.op)
			pfsa_pkg::OP_LOAD: begin
				addr_q       <= in_data.address;
				len_q        <= in_data.length;
				vs_q         <= vs_sat;
				res_status_q <= pfsa_pkg::ST_OK;
				res_page_q   <= '0;
				added_q      <= '0;
			end
			pfsa_pkg::OP_RANGE: begin
				ve_q <= ve_sat;
				lo_q <= (vs_q > kend_q) ? vs_q : kend_q;
			end
			pfsa_pkg::OP_CLIP: begin
				hi_q   <= (ve_q < mend_q) ? ve_q : mend_q;
				lovf_q <= (lo_q > ADDR_MAX - PAGE_MASK);
				cur_q  <= (lo_q + PAGE_MASK) & ~PAGE_MASK;
			end
			pfsa_pkg::OP_LIMIT: begin
				lim_q <= hi_q - PAGE_BYTES;
				bad_q <= lovf_q || (hi_q < PAGE_BYTES);
			end
			pfsa_pkg::OP_WALK: begin
				if (page_fits && stack_full)
					res_status_q <= pfsa_pkg::ST_FULL;
				else if (page_fits)
					cur_q <= cur_q + PAGE_BYTES;
			end
			pfsa_pkg::OP_FREE: begin
				if (free_mis)
					res_status_q <= pfsa_pkg::ST_MISALIGNED;
				else if (free_rng)
					res_status_q <= pfsa_pkg::ST_RANGE;
				else if (stack_full)
					res_status_q <= pfsa_pkg::ST_FULL;
			end
			pfsa_pkg::OP_POP: begin
				if (count_q == '0)
					res_status_q <= pfsa_pkg::ST_EMPTY;
			end
			pfsa_pkg::OP_POPW: begin
				if (res_status_q == pfsa_pkg::ST_OK)
					res_page_q <= pfsa_pkg::ADDR_W'(rd_q) << PAGE_SHIFT;
			end
			default: ;
		endcase
	end

endmodule
